// ===== design/cms_pkg.sv =====
`default_nettype none

package cms_pkg;

	// register reset values
	localparam logic [15:0] CUT_TIMEOUT_RESET = 16'd3000;
	localparam logic [15:0] BRAKE_TIME_RESET  = 16'd100;

	// configuration register indexes
	localparam logic CFG_CUT_TIMEOUT = 1'b0;
	localparam logic CFG_BRAKE_TIME  = 1'b1;

	// event kinds
	typedef enum logic [1:0] {
		EV_TICK   = 2'd0,
		EV_CUT    = 2'd1,
		EV_RESET  = 2'd2,
		EV_EDGE   = 2'd3
	} kind_t;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FIRST  = 3'd1,
		PH_SECOND = 3'd2,
		PH_BRAKE  = 3'd3,
		PH_HOME   = 3'd4
	} phase_t;

	// motor drive codes
	typedef enum logic [1:0] {
		DRV_OFF     = 2'd0,
		DRV_REVERSE = 2'd1,
		DRV_FORWARD = 2'd2,
		DRV_BRAKE   = 2'd3
	} drive_t;

	// one input event
	typedef struct packed {
		logic  switch_level;
		kind_t kind;
	} item_t;

	// one result, packed as on the output tdata
	typedef struct packed {
		logic   cutter_error;
		logic   idle;
		logic   power_enable;
		drive_t motor_drive;
	} result_t;

	// internal status for checking
	typedef struct packed {
		logic   armed;
		drive_t drive;
	} status_t;

endpackage

`default_nettype wire

// ===== design/cutter_motor_sequencer.sv =====
`default_nettype none

// Paper-cutter motor sequencer. Each input transfer carries one event (1 ms
// tick, cut command, reset or home-switch falling edge) and produces exactly
// one output transfer with the drive code, power enable, idle and error
// flags as they stand after that event. One event is taken every cycle
// unless output back-pressure stalls the input stage; an event passes the
// input register, then the sequencer core, whose state update feeds the
// output register. The configuration port writes the cut timeout (index 0)
// and the brake time (index 1), both in milliseconds; write them only while
// no event is in flight.
module cutter_motor_sequencer
	import cms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [1:0] kind, [2] switch_level, [7:3] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [1:0] motor_drive, [2] power_enable, [3] idle,
	                                        // [4] cutter_error, [7:5] zero
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    step;
	result_t result;
	status_t status;

	// event retires when the output register can take its result
	assign step = valid_s1 && out_free;

	cms_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.advance       (out_free),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	cms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item_s1   (item_s1),
		.result    (result),
		.status    (status)
	);

	cms_out_stage u_out_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step),
		.result        (result),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// a stalled event holds in the input stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost or changed a stalled event");

	// a retiring event always shows up as an output transfer
	a_retire_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_axis_tvalid)
		else $error("retired event produced no output");

	// the edge is only armed while the motor runs in reverse
	a_armed_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		status.armed |-> (status.drive == DRV_REVERSE))
		else $error("edge armed while motor not in reverse");

endmodule

`default_nettype wire

// ===== design/cms_in_stage.sv =====
`default_nettype none

module cms_in_stage
	import cms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [1:0] kind, [2] switch_level, [7:3] zero
	input  wire logic       advance,
	output logic            valid_s1,
	output item_t           item_s1
);

	// stage may load when empty or when its item moves on
	assign s_axis_tready = !valid_s1 || advance;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind         <= kind_t'(s_axis_tdata[1:0]);
			item_s1.switch_level <= s_axis_tdata[2];
		end
	end

endmodule

`default_nettype wire

// ===== design/cms_core.sv =====
`default_nettype none

module cms_core
	import cms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        step,
	input  wire item_t       item_s1,
	output result_t          result,
	output status_t          status
);

	logic [15:0] cut_timeout_q;
	logic [15:0] brake_time_q;

	phase_t      phase_q, phase_d;
	logic [15:0] remaining_q, remaining_d;
	logic        armed_q, armed_d;
	drive_t      drive_q, drive_d;
	logic        power_q, power_d;
	logic        error_q, error_d;

	logic [15:0] remaining_dec;
	logic        expired;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_timeout_q <= CUT_TIMEOUT_RESET;
			brake_time_q  <= BRAKE_TIME_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_CUT_TIMEOUT: cut_timeout_q <= cfg_wdata;
				CFG_BRAKE_TIME:  brake_time_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// countdown step, saturating at zero
	assign remaining_dec = (remaining_q != 16'd0) ? remaining_q - 16'd1 : 16'd0;
	assign expired       = (remaining_dec == 16'd0);

	// next state for the event in the input stage
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		armed_d     = armed_q;
		drive_d     = drive_q;
		power_d     = power_q;
		error_d     = error_q;
		case (item_s1.kind)
			EV_TICK: begin
				remaining_d = remaining_dec;
				case (phase_q)
					PH_IDLE: ;
					PH_FIRST: begin
						if (expired) begin
							drive_d     = DRV_REVERSE;
							armed_d     = 1'b1;
							remaining_d = cut_timeout_q;
							phase_d     = PH_SECOND;
						end
					end
					PH_SECOND: begin
						if (expired) begin
							drive_d = DRV_OFF;
							armed_d = 1'b0;
							error_d = 1'b1;
							phase_d = PH_IDLE;
						end
					end
					PH_BRAKE: begin
						if (expired) begin
							drive_d = DRV_OFF;
							error_d = 1'b0;
							phase_d = PH_HOME;
						end
					end
					PH_HOME: begin
						if (item_s1.switch_level) begin
							power_d     = 1'b1;
							drive_d     = DRV_REVERSE;
							armed_d     = 1'b1;
							remaining_d = cut_timeout_q;
							error_d     = 1'b0;
							phase_d     = PH_SECOND;
						end else begin
							power_d = 1'b0;
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			EV_CUT: begin
				power_d     = 1'b1;
				drive_d     = DRV_REVERSE;
				armed_d     = 1'b1;
				remaining_d = cut_timeout_q;
				phase_d     = PH_FIRST;
			end
			EV_RESET: begin
				armed_d = 1'b0;
				phase_d = PH_HOME;
				error_d = 1'b0;
			end
			EV_EDGE: begin
				if (armed_q) begin
					drive_d     = DRV_BRAKE;
					armed_d     = 1'b0;
					phase_d     = PH_BRAKE;
					remaining_d = brake_time_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HOME;
			remaining_q <= 16'd0;
			armed_q     <= 1'b0;
			drive_q     <= DRV_OFF;
			power_q     <= 1'b0;
			error_q     <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			armed_q     <= armed_d;
			drive_q     <= drive_d;
			power_q     <= power_d;
			error_q     <= error_d;
		end
	end

	// result shows the state after the event
	assign result.motor_drive  = drive_d;
	assign result.power_enable = power_d;
	assign result.idle         = (phase_d == PH_IDLE);
	assign result.cutter_error = error_d;

	assign status.armed = armed_q;
	assign status.drive = drive_q;

endmodule

`default_nettype wire

// ===== design/cms_out_stage.sv =====
`default_nettype none

module cms_out_stage
	import cms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire result_t    result,
	output logic            out_free,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata  // [1:0] motor_drive, [2] power_enable, [3] idle,
	                                      // [4] cutter_error, [7:5] zero
);

	result_t data_q;

	// register may take a new result when empty or being drained
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= load;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign m_axis_tdata = {3'b000, data_q};

endmodule

`default_nettype wire

// ===== tb/cms_checker.sv =====
`default_nettype none

module cms_checker
	import cms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [1:0] kind, [2] switch_level, [7:3] zero
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [7:0]  m_axis_tdata,  // [1:0] motor_drive, [2] power_enable, [3] idle,
	                                        // [4] cutter_error, [7:5] zero
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	output int               mismatch_count,
	output int               results_due
);

	// mirrored registers
	logic [15:0] cut_timeout;
	logic [15:0] brake_time;

	// mirrored sequencer state
	phase_t      phase;
	logic [15:0] remaining;
	logic        armed;
	drive_t      drive;
	logic        power;
	logic        err;

	// predicted motor status, oldest first
	result_t     awaited_status[$];
	result_t     got;
	result_t     want;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// load a reverse drive window and arm the home edge
	task automatic open_reverse_window();
		drive     = DRV_REVERSE;
		armed     = 1'b1;
		remaining = cut_timeout;
	endtask

	// advance the sequencer by one event and give the status after it
	task automatic sequence_event(input item_t ev, output result_t status);
		logic expired;
		case (ev.kind)
			EV_TICK: begin
				if (remaining != 16'd0)
					remaining = remaining - 16'd1;
				expired = (remaining == 16'd0);
				case (phase)
					PH_IDLE: ;
					PH_FIRST: begin
						if (expired) begin
							open_reverse_window();
							phase = PH_SECOND;
						end
					end
					PH_SECOND: begin
						if (expired) begin
							drive = DRV_OFF;
							armed = 1'b0;
							err   = 1'b1;
							phase = PH_IDLE;
						end
					end
					PH_BRAKE: begin
						if (expired) begin
							drive = DRV_OFF;
							err   = 1'b0;
							phase = PH_HOME;
						end
					end
					PH_HOME: begin
						if (ev.switch_level) begin
							power = 1'b1;
							open_reverse_window();
							err   = 1'b0;
							phase = PH_SECOND;
						end else begin
							power = 1'b0;
							phase = PH_IDLE;
						end
					end
					default: phase = PH_IDLE;
				endcase
			end
			EV_CUT: begin
				power = 1'b1;
				open_reverse_window();
				phase = PH_FIRST;
			end
			EV_RESET: begin
				armed = 1'b0;
				phase = PH_HOME;
				err   = 1'b0;
			end
			default: begin
				// home edge only counts while armed
				if (armed) begin
					drive     = DRV_BRAKE;
					armed     = 1'b0;
					phase     = PH_BRAKE;
					remaining = brake_time;
				end
			end
		endcase
		status.motor_drive  = drive;
		status.power_enable = power;
		status.idle         = (phase == PH_IDLE);
		status.cutter_error = err;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_timeout    = CUT_TIMEOUT_RESET;
			brake_time     = BRAKE_TIME_RESET;
			phase          = PH_HOME;
			remaining      = 16'd0;
			armed          = 1'b0;
			drive          = DRV_OFF;
			power          = 1'b0;
			err            = 1'b0;
			mismatch_count = 0;
			awaited_status.delete();
			results_due   <= 0;
		end else begin
			// output transfer against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[4:0]);
				if (awaited_status.size() == 0) begin
					report_mismatch($sformatf("result %0h with none awaited", m_axis_tdata));
				end else begin
					want = awaited_status.pop_front();
					if (got.motor_drive != want.motor_drive)
						report_mismatch($sformatf("motor_drive expected %0d got %0d",
							want.motor_drive, got.motor_drive));
					if (got.power_enable != want.power_enable)
						report_mismatch($sformatf("power_enable expected %0d got %0d",
							want.power_enable, got.power_enable));
					if (got.idle != want.idle)
						report_mismatch($sformatf("idle expected %0d got %0d",
							want.idle, got.idle));
					if (got.cutter_error != want.cutter_error)
						report_mismatch($sformatf("cutter_error expected %0d got %0d",
							want.cutter_error, got.cutter_error));
				end
			end
			// input transfer
			if (s_axis_tvalid && s_axis_tready) begin
				sequence_event(item_t'(s_axis_tdata[2:0]), want);
				awaited_status.push_back(want);
			end
			// register writes
			if (cfg_wen) begin
				case (cfg_index)
					CFG_CUT_TIMEOUT: cut_timeout = cfg_wdata;
					CFG_BRAKE_TIME:  brake_time  = cfg_wdata;
					default: ;
				endcase
			end
			results_due <= awaited_status.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_cutter_motor_sequencer.sv =====
`default_nettype none

module tb_cutter_motor_sequencer;
	import cms_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_COUNT  = 12;
	localparam int PHASE_EVENTS = 125;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_wen       = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [15:0] cfg_wdata     = 16'd0;

	int          mismatch_count;
	int          results_due;
	int          cycle_count   = 0;
	int          events_sent   = 0;
	int          ready_hold    = 0;
	logic        steady        = 1'b0;
	int          cut_ms        = 3000;
	int          brake_ms      = 100;

	cutter_motor_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	cms_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// number of ticks to try against a window of the given length
	function automatic int tick_span(input int ms);
		if (ms > 20)
			return $urandom_range(0, 40);
		return $urandom_range(0, 2 * ms + 2);
	endfunction

	function automatic logic any_level();
		return 1'($urandom_range(0, 1));
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		if (steady) begin
			m_axis_tready = 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready = 1'b0;
			ready_hold    = pick_gap();
		end else begin
			m_axis_tready = 1'b1;
			ready_hold    = $urandom_range(0, 6);
		end
	end

	// one event transfer, with an optional gap ahead of it
	task automatic send_event(input kind_t kind, input logic level);
		int gap;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {5'd0, level, kind};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		events_sent++;
	endtask

	// hold off until every status has come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [15:0] value);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic set_timing(input int cut_value, input int brake_value);
		drain();
		write_reg(CFG_CUT_TIMEOUT, 16'(cut_value));
		write_reg(CFG_BRAKE_TIME, 16'(brake_value));
		cut_ms   = cut_value;
		brake_ms = brake_value;
	endtask

	// cut, reverse windows, home edge, brake and home check
	task automatic cut_cycle();
		send_event(EV_CUT, any_level());
		repeat (tick_span(cut_ms)) send_event(EV_TICK, any_level());
		if ($urandom_range(0, 9) < 7)
			send_event(EV_EDGE, any_level());
		repeat (tick_span(brake_ms)) send_event(EV_TICK, any_level());
		repeat ($urandom_range(1, 3)) send_event(EV_TICK, any_level());
		if ($urandom_range(0, 9) == 0)
			send_event(EV_RESET, any_level());
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 4))
			send_event(kind_t'($urandom_range(0, 3)), any_level());
	endtask

	initial begin
		int target;
		int cut_pick;
		int brake_pick;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset timing values
		send_event(EV_TICK, 1'b0);
		send_event(EV_EDGE, 1'b1);
		send_event(EV_CUT, 1'b0);
		send_event(EV_TICK, 1'b1);
		send_event(EV_EDGE, 1'b0);
		send_event(EV_RESET, 1'b1);
		send_event(EV_TICK, 1'b1);

		// directed: short windows, both timeouts, brake and home check
		set_timing(2, 1);
		send_event(EV_CUT, 1'b1);
		send_event(EV_TICK, 1'b0);
		send_event(EV_TICK, 1'b1);
		send_event(EV_TICK, 1'b0);
		send_event(EV_TICK, 1'b1);
		send_event(EV_TICK, 1'b0);
		send_event(EV_CUT, 1'b0);
		send_event(EV_EDGE, 1'b1);
		send_event(EV_TICK, 1'b0);
		send_event(EV_TICK, 1'b1);
		send_event(EV_EDGE, 1'b0);
		send_event(EV_TICK, 1'b1);
		send_event(EV_TICK, 1'b0);
		send_event(EV_RESET, 1'b0);
		send_event(EV_EDGE, 1'b1);
		send_event(EV_TICK, 1'b1);
		send_event(EV_RESET, 1'b1);

		// random phases over several timing settings
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin cut_pick = 1; brake_pick = 1; end
				1: begin cut_pick = 65535; brake_pick = 65535; end
				2: begin cut_pick = 0; brake_pick = 0; end
				3: begin cut_pick = 3000; brake_pick = 100; end
				default: begin
					cut_pick   = $urandom_range(1, 12);
					brake_pick = $urandom_range(1, 12);
				end
			endcase
			set_timing(cut_pick, brake_pick);
			steady = (p % 4 == 3);
			target = events_sent + PHASE_EVENTS;
			while (events_sent < target) begin
				if ($urandom_range(0, 9) < 8)
					cut_cycle();
				else
					noise_burst();
			end
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
